// ----- design/bgs_pkg.sv -----
// Shared widths, defaults and request codes for the bilinear grid sampler.
package bgs_pkg;

    localparam int HEIGHT_W        = 16;
    localparam int COORD_W         = 17;
    localparam int WIDX_W          = 16;
    localparam int GSIZE_W         = 9;

    localparam int DEF_MAX_SIDE    = 256;
    localparam int DEF_FRAC_BITS   = 8;
    localparam int GRID_SIZE_RESET = 256;
    localparam int SIDE_MIN        = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

// ----- design/bgs_clamp.sv -----
// Coordinate clamp-to-edge and split into integer index, next index and fraction.
module bgs_clamp #(
    parameter int MAX_SIDE  = bgs_pkg::DEF_MAX_SIDE,
    parameter int FRAC_BITS = bgs_pkg::DEF_FRAC_BITS
) (
    input  logic signed [bgs_pkg::COORD_W-1:0]  i_coord,
    input  logic [$clog2(MAX_SIDE+1)-1:0]        i_side,
    output logic [$clog2(MAX_SIDE)-1:0]          o_idx0,
    output logic [$clog2(MAX_SIDE)-1:0]          o_idx1,
    output logic [FRAC_BITS-1:0]                 o_frac
);
    import bgs_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIDE);
    localparam int UW    = IDX_W + FRAC_BITS;
    localparam int CW    = ((COORD_W > UW) ? COORD_W : UW) + 1;

    logic [IDX_W-1:0]     side_m1;
    logic signed [CW-1:0] coord_ext;
    logic signed [CW-1:0] top;
    logic [UW-1:0]        clamped;

    always_comb begin
        side_m1   = IDX_W'(i_side - 1'b1);
        coord_ext = CW'(i_coord);
        top       = $signed(CW'({side_m1, {FRAC_BITS{1'b0}}}));
        if (coord_ext[CW-1]) begin
            clamped = '0;
        end else if (coord_ext > top) begin
            clamped = UW'(top);
        end else begin
            clamped = UW'(coord_ext);
        end
        o_idx0 = clamped[UW-1:FRAC_BITS];
        o_frac = clamped[FRAC_BITS-1:0];
        // next sample sticks to the last column or row at the edge
        if (o_idx0 == side_m1) begin
            o_idx1 = o_idx0;
        end else begin
            o_idx1 = o_idx0 + 1'b1;
        end
    end

endmodule

// ----- design/bilinear_grid_sampler.sv -----
// Bilinear height sampler over a square grid with clamp-to-edge addressing.
// Takes one request per clock while the pipeline is not stalled and gives one height per query;
// a write request stores a sample and gives no result. The grid lives in two copies of
// a MAX_SIDE*MAX_SIDE memory with two read ports each, so all four neighbours are read in the
// same cycle, and writes land in the same stage that queries read, keeping requests in order. Grid
// entries hold no defined value until written; a query must only touch written entries. A write
// index beyond the store is dropped. grid_size below 2 acts as 2 and above MAX_SIDE as MAX_SIDE.
// Write grid_size only while no request is in flight.
module bilinear_grid_sampler #(
    parameter int MAX_SIDE  = bgs_pkg::DEF_MAX_SIDE,
    parameter int FRAC_BITS = bgs_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bgs_pkg::GSIZE_W-1:0]          i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_kind,
    input  logic [bgs_pkg::WIDX_W-1:0]           i_write_index,
    input  logic signed [bgs_pkg::HEIGHT_W-1:0]  i_write_value,
    input  logic signed [bgs_pkg::COORD_W-1:0]   i_query_x,
    input  logic signed [bgs_pkg::COORD_W-1:0]   i_query_z,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [bgs_pkg::HEIGHT_W-1:0]  o_height
);
    import bgs_pkg::*;

    localparam int IDX_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DW       = HEIGHT_W + 1;
    localparam int PW       = DW + FRAC_BITS + 1;
    localparam int NSTG     = 7;
    localparam int SIDE_RST = (GRID_SIZE_RESET > MAX_SIDE) ? MAX_SIDE : GRID_SIZE_RESET;

    // grid size, held already clamped
    logic [SIDE_W-1:0] r_side, n_side;

    logic [NSTG:1]   r_vld, n_vld;
    logic [NSTG+1:1] ld;

    // stage 1: clamped coordinates
    logic [IDX_W-1:0]     cx_i0, cx_i1, cz_i0, cz_i1;
    logic [FRAC_BITS-1:0] cx_f, cz_f;
    logic                 r1_kind;
    logic [WIDX_W-1:0]    r1_widx;
    logic [HEIGHT_W-1:0]  r1_wval;
    logic [IDX_W-1:0]     r1_ix0, r1_ix1, r1_iz0, r1_iz1;
    logic [FRAC_BITS-1:0] r1_fx, r1_fz;

    // stage 2: memory addresses
    logic                 r2_kind;
    logic                 r2_wok;
    logic [ADDR_W-1:0]    r2_waddr;
    logic [HEIGHT_W-1:0]  r2_wval;
    logic [ADDR_W-1:0]    r2_addr_a, r2_addr_b, r2_addr_c, r2_addr_d;
    logic [FRAC_BITS-1:0] r2_fx, r2_fz;

    // stage 3: memory read
    logic [HEIGHT_W-1:0]  mem_ab [DEPTH];
    logic [HEIGHT_W-1:0]  mem_cd [DEPTH];
    logic                 mem_we, mem_re;
    logic signed [HEIGHT_W-1:0] r3_a, r3_b, r3_c, r3_d;
    logic [FRAC_BITS-1:0] r3_fx, r3_fz;

    // stages 4 to 7: lerps
    logic signed [DW-1:0]       dab, dcd, dz;
    logic signed [HEIGHT_W-1:0] r4_a, r4_c;
    logic signed [PW-1:0]       r4_pab, r4_pcd;
    logic [FRAC_BITS-1:0]       r4_fz;
    logic signed [HEIGHT_W-1:0] r5_ab, r5_cd;
    logic [FRAC_BITS-1:0]       r5_fz;
    logic signed [HEIGHT_W-1:0] r6_ab;
    logic signed [PW-1:0]       r6_pz;
    logic signed [HEIGHT_W-1:0] r_out_height;

    always_comb begin
        n_side = r_side;
        if (i_cfg_we) begin
            if (int'(i_cfg_data) < SIDE_MIN) begin
                n_side = SIDE_W'(SIDE_MIN);
            end else if (int'(i_cfg_data) > MAX_SIDE) begin
                n_side = SIDE_W'(MAX_SIDE);
            end else begin
                n_side = SIDE_W'(i_cfg_data);
            end
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        ld[NSTG+1] = i_ready;
        for (int k = NSTG; k >= 1; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        n_vld = r_vld;
        for (int k = 1; k <= NSTG; k++) begin
            if (ld[k]) begin
                if (k == 1) begin
                    n_vld[k] = i_valid;
                end else if (k == 3) begin
                    // drop write requests once they reach the memory
                    n_vld[k] = r_vld[2] && (r2_kind == KIND_QUERY);
                end else begin
                    n_vld[k] = r_vld[k-1];
                end
            end
        end
    end

    assign o_ready  = ld[1];
    assign o_valid  = r_vld[NSTG];
    assign o_height = r_out_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_W'(SIDE_RST);
            r_vld  <= '0;
        end else begin
            r_side <= n_side;
            r_vld  <= n_vld;
        end
    end

    bgs_clamp #(.MAX_SIDE(MAX_SIDE), .FRAC_BITS(FRAC_BITS)) u_clamp_x (
        .i_coord (i_query_x),
        .i_side  (r_side),
        .o_idx0  (cx_i0),
        .o_idx1  (cx_i1),
        .o_frac  (cx_f)
    );

    bgs_clamp #(.MAX_SIDE(MAX_SIDE), .FRAC_BITS(FRAC_BITS)) u_clamp_z (
        .i_coord (i_query_z),
        .i_side  (r_side),
        .o_idx0  (cz_i0),
        .o_idx1  (cz_i1),
        .o_frac  (cz_f)
    );

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r1_kind <= i_kind;
            r1_widx <= i_write_index;
            r1_wval <= i_write_value;
            r1_ix0  <= cx_i0;
            r1_ix1  <= cx_i1;
            r1_iz0  <= cz_i0;
            r1_iz1  <= cz_i1;
            r1_fx   <= cx_f;
            r1_fz   <= cz_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r2_kind   <= r1_kind;
            r2_wok    <= (32'(r1_widx) < 32'(DEPTH));
            r2_waddr  <= ADDR_W'(r1_widx);
            r2_wval   <= r1_wval;
            r2_addr_a <= ADDR_W'(ADDR_W'(r1_iz0) * ADDR_W'(r_side) + ADDR_W'(r1_ix0));
            r2_addr_b <= ADDR_W'(ADDR_W'(r1_iz0) * ADDR_W'(r_side) + ADDR_W'(r1_ix1));
            r2_addr_c <= ADDR_W'(ADDR_W'(r1_iz1) * ADDR_W'(r_side) + ADDR_W'(r1_ix0));
            r2_addr_d <= ADDR_W'(ADDR_W'(r1_iz1) * ADDR_W'(r_side) + ADDR_W'(r1_ix1));
            r2_fx     <= r1_fx;
            r2_fz     <= r1_fz;
        end
    end

    assign mem_we = ld[3] && r_vld[2] && (r2_kind == KIND_WRITE) && r2_wok;
    assign mem_re = ld[3] && r_vld[2] && (r2_kind == KIND_QUERY);

    // both copies take every write; the upper row copy feeds a and b, the lower c and d
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_ab[r2_waddr] <= r2_wval;
            mem_cd[r2_waddr] <= r2_wval;
        end
        if (mem_re) begin
            r3_a  <= mem_ab[r2_addr_a];
            r3_b  <= mem_ab[r2_addr_b];
            r3_c  <= mem_cd[r2_addr_c];
            r3_d  <= mem_cd[r2_addr_d];
            r3_fx <= r2_fx;
            r3_fz <= r2_fz;
        end
    end

    always_comb begin
        dab = DW'(r3_b) - DW'(r3_a);
        dcd = DW'(r3_d) - DW'(r3_c);
        dz  = DW'(r5_cd) - DW'(r5_ab);
    end

    // arithmetic shift of the product floors toward minus infinity
    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r4_a   <= r3_a;
            r4_c   <= r3_c;
            r4_pab <= PW'(dab) * PW'($signed({1'b0, r3_fx}));
            r4_pcd <= PW'(dcd) * PW'($signed({1'b0, r3_fx}));
            r4_fz  <= r3_fz;
        end
        if (ld[5]) begin
            r5_ab <= HEIGHT_W'(PW'(r4_a) + (r4_pab >>> FRAC_BITS));
            r5_cd <= HEIGHT_W'(PW'(r4_c) + (r4_pcd >>> FRAC_BITS));
            r5_fz <= r4_fz;
        end
        if (ld[6]) begin
            r6_ab <= r5_ab;
            r6_pz <= PW'(dz) * PW'($signed({1'b0, r5_fz}));
        end
        if (ld[7]) begin
            r_out_height <= HEIGHT_W'(PW'(r6_ab) + (r6_pz >>> FRAC_BITS));
        end
    end

    // memory port is either written or read in a cycle, never both
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("grid memory written and read in the same cycle");

    // refusing a request means the first stage is occupied and blocked
    a_ready_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_vld[1] && !ld[2]))
        else $error("request refused with room in the first stage");

    // a full pipeline with a stalled result takes no request
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_vld == '1) && !i_ready) |-> !o_ready)
        else $error("request taken while the full pipeline is stalled");

    // a result left waiting is still there next cycle
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG] && !i_ready) |=> (r_vld[NSTG] && $stable(r_out_height)))
        else $error("waiting result lost or changed");

endmodule
